### design/bldr_pkg.sv
`default_nettype none
package bldr_pkg;
    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_RAW     = 3'd1;
    localparam logic [2:0] PH_COUNTER = 3'd2;
    localparam logic [2:0] PH_NUMBER  = 3'd3;
    localparam logic [2:0] PH_LITERAL = 3'd4;
    localparam logic [2:0] PH_COPY    = 3'd5;

    localparam logic [1:0] FN_PUSH = 2'd0;
    localparam logic [1:0] FN_TICK = 2'd1;
    localparam logic [1:0] FN_END  = 2'd2;

    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_STATUS  = 2'd1;
    localparam logic [1:0] KIND_REFUSED = 2'd2;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_SHORT  = 3'd1;
    localparam logic [2:0] ST_NODATA = 3'd2;
    localparam logic [2:0] ST_REF    = 3'd3;
    localparam logic [2:0] ST_OVER   = 3'd4;
    localparam logic [2:0] ST_TRUNC  = 3'd5;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BIGEND = 2'd2;

    localparam int HEADER_LEN = 132;

    // controller to datapath
    typedef struct packed {
        logic start;       // latch the item into the datapath
        logic clear_step;  // write one store entry during clearing
        logic clear_first; // begin clear pass
        logic emit;        // final stage: finish item
    } bldr_cmd_t;

    typedef struct packed {
        logic clear_done;
    } bldr_stat_t;
endpackage
`default_nettype wire

### design/band_lz_decompress_rotate_core.sv
`default_nettype none
// channel   dir  handshake             payload
// s_axis    in   s_tvalid/s_tready     tdata: in_byte, tuser: func
// m_axis    out  m_tvalid/m_tready     tdata: out_address,out_value,status; tuser: out_kind
// cfg       in   cfg_valid/cfg_ready   cfg_index, cfg_data
// an item passes accept, store read and update, plus output wait
// after reset and after each end of band the store is refilled with 0xff;
// s_tready stays low meanwhile
// a stalled result holds the block; aresetn is synchronous, active low
module band_lz_decompress_rotate_core import bldr_pkg::*; #(
    parameter int BAND_BYTES = 65536
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // in_byte
    input  wire logic [1:0]  s_tuser,   // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // out_address[15:0], out_value[23:16], status[26:24]
    output logic [1:0]       m_tuser,   // out_kind
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    logic [15:0] width_reg, height_reg;
    logic        bigend_reg;
    bldr_cmd_t   cmd;
    bldr_stat_t  stat;
    logic        rv, restart, in_rdy;
    logic [1:0]  rk;
    logic [15:0] ra;
    logic [7:0]  rvv;
    logic [2:0]  rs;
    logic        ctl_rst_n;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= 16'd4960; height_reg <= 16'd128; bigend_reg <= 1'b1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                CFG_BIGEND: bigend_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) m_tvalid <= 1'b0;
        else if (rv) m_tvalid <= 1'b1;
        else if (m_tready) m_tvalid <= 1'b0;
        if (rv) begin
            m_tdata <= {5'b0, rs, rvv, ra};
            m_tuser <= rk;
        end
    end

    // end of band restarts the controller into its clear pass
    // no transaction is taken in the restart cycle
    assign ctl_rst_n = aresetn && !restart;
    assign s_tready = in_rdy && !restart;

    bldr_ctrl u_ctrl (
        .aclk, .aresetn(ctl_rst_n), .in_fire(s_tvalid && s_tready),
        .out_free(!m_tvalid || m_tready), .stat, .cmd, .in_ready(in_rdy)
    );

    bldr_datapath #(.BAND_BYTES(BAND_BYTES)) u_dp (
        .aclk, .aresetn, .cmd, .stat, .func(s_tuser), .in_byte(s_tdata),
        .band_width(width_reg), .band_height(height_reg), .big_endian(bigend_reg),
        .res_valid(rv), .res_kind(rk), .res_addr(ra), .res_value(rvv),
        .res_status(rs), .restart
    );

    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_step |-> !s_tready) else $error("accept during clear");
    a_result_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        rv |-> $past(cmd.emit)) else $error("result without emit");
    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        restart |=> cmd.clear_step) else $error("no clear after end");
endmodule
`default_nettype wire

### design/bldr_ctrl.sv
`default_nettype none
module bldr_ctrl import bldr_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_fire,
    input  wire logic       out_free,
    input  wire bldr_stat_t stat,
    output bldr_cmd_t       cmd,
    output logic            in_ready
);
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       first_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            first_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            first_reg <= 1'b0;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                cmd.clear_first = first_reg;
                if (stat.clear_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_fire) begin
                    cmd.start = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ: state_next = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    cmd.emit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end
endmodule
`default_nettype wire

### design/bldr_datapath.sv
`default_nettype none
module bldr_datapath import bldr_pkg::*; #(
    parameter int BAND_BYTES = 65536
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire bldr_cmd_t   cmd,
    output bldr_stat_t       stat,
    input  wire logic [1:0]  func,
    input  wire logic [7:0]  in_byte,
    input  wire logic [15:0] band_width,
    input  wire logic [15:0] band_height,
    input  wire logic        big_endian,
    output logic             res_valid,
    output logic [1:0]       res_kind,
    output logic [15:0]      res_addr,
    output logic [7:0]       res_value,
    output logic [2:0]       res_status,
    output logic             restart
);
    localparam int AW = $clog2(BAND_BYTES);
    // copy source spans the whole signed offset range on any store size
    localparam int SW = (AW > 16) ? AW + 2 : 18;

    logic [7:0]  store [BAND_BYTES];
    logic [15:0] otab [64];

    logic [1:0]  func_reg;
    logic [7:0]  byte_reg;
    logic [7:0]  rd_reg;
    logic [15:0] tab_rd_reg;
    logic [AW:0] wpos_reg;
    logic [2:0]  phase_reg;
    logic [7:0]  hcnt_reg;
    logic [31:0] raw_reg;
    logic [7:0]  held_reg;
    logic [9:0]  run_reg;
    logic [SW-1:0] src_reg;   // signed copy source
    logic [15:0] col_reg, rowc_reg;
    logic [16:0] rbase_reg;
    logic [2:0]  flags_reg;
    logic [AW:0] clr_reg;
    logic [AW:0] limit_reg;
    logic [31:0] prod_reg;

    // band size, registered
    always_ff @(posedge aclk) begin
        prod_reg <= band_width * band_height;
        if ((({1'b0, prod_reg} + 33'd7) >> 3) > 33'(BAND_BYTES))
            limit_reg <= (AW+1)'(BAND_BYTES);
        else
            limit_reg <= (AW+1)'((prod_reg + 32'd7) >> 3);
    end

    assign stat.clear_done = (clr_reg == (AW+1)'(BAND_BYTES - 1));

    logic src_bad;
    assign src_bad = src_reg[SW-1] || (src_reg[SW-2:0] >= (SW-1)'(limit_reg));

    logic [7:0] hk;
    assign hk = hcnt_reg - 8'd4;

    // store port: clear write, read at start, byte write at emit
    // the table is read at start: the stored first byte of a header word,
    // or the entry a number byte selects
    logic        do_emit;
    logic [7:0]  emit_b;
    always_ff @(posedge aclk) begin
        if (cmd.clear_step)
            store[cmd.clear_first ? '0 : clr_reg[AW-1:0]] <= 8'hFF;
        else if (cmd.emit && do_emit && wpos_reg < limit_reg)
            store[wpos_reg[AW-1:0]] <= emit_b;
        if (cmd.start)
            rd_reg <= store[src_reg[AW-1:0]];
        if (cmd.start)
            tab_rd_reg <= otab[(phase_reg == PH_HEADER) ? hk[6:1] : in_byte[5:0]];
    end

    always_comb begin
        do_emit = 1'b0;
        emit_b = byte_reg;
        if (func_reg == FN_PUSH) begin
            if (phase_reg == PH_RAW && raw_reg != 0) do_emit = 1'b1;
            if (phase_reg == PH_LITERAL) do_emit = 1'b1;
        end else if (func_reg == FN_TICK && phase_reg == PH_COPY) begin
            do_emit = 1'b1;
            emit_b = src_bad ? 8'hFF : rd_reg;
        end
    end

    logic [2:0] st;
    logic [2:0] fl_end;
    always_comb begin
        fl_end = flags_reg | ((phase_reg != PH_COUNTER) ? 3'b100 : 3'b000);
        if (phase_reg == PH_HEADER) st = ST_SHORT;
        else if (phase_reg == PH_RAW) st = ST_NODATA;
        else if (fl_end[0]) st = ST_REF;
        else if (fl_end[1]) st = ST_OVER;
        else if (fl_end[2]) st = ST_TRUNC;
        else st = ST_OK;
    end

    always_ff @(posedge aclk) begin
        res_valid <= 1'b0;
        restart <= 1'b0;
        if (cmd.start) begin
            func_reg <= func;
            byte_reg <= in_byte;
        end
        if (cmd.clear_step)
            clr_reg <= cmd.clear_first ? (AW+1)'(1) : clr_reg + 1'b1;
        if (cmd.emit) begin
            res_kind <= KIND_BYTE;
            res_addr <= '0;
            res_value <= '0;
            res_status <= ST_OK;
            if (func_reg == FN_END) begin
                res_valid <= 1'b1;
                res_kind <= KIND_STATUS;
                res_status <= st;
                restart <= 1'b1;
            end else if (func_reg == FN_PUSH && phase_reg == PH_COPY) begin
                res_valid <= 1'b1;
                res_kind <= KIND_REFUSED;
            end else if (func_reg == FN_PUSH) begin
                unique case (phase_reg)
                    PH_HEADER: begin
                        if (hcnt_reg < 8'd4) begin
                            if (big_endian) raw_reg <= {raw_reg[23:0], byte_reg};
                            else raw_reg <= raw_reg | (32'(byte_reg) << {hcnt_reg[1:0], 3'b0});
                        end else if (!hk[0]) begin
                            otab[hk[6:1]] <= big_endian ? {byte_reg, 8'h00}
                                                        : {8'h00, byte_reg};
                        end else begin
                            otab[hk[6:1]] <= ~(tab_rd_reg | (big_endian
                                ? {8'h00, byte_reg} : {byte_reg, 8'h00}));
                        end
                        hcnt_reg <= hcnt_reg + 1'b1;
                        if (hcnt_reg + 8'd1 >= 8'(HEADER_LEN)) phase_reg <= PH_RAW;
                    end
                    PH_RAW: begin
                        if (raw_reg != 0) raw_reg <= raw_reg - 1'b1;
                        else if (byte_reg[7]) begin
                            held_reg <= byte_reg; phase_reg <= PH_NUMBER;
                        end else begin
                            run_reg <= 10'(byte_reg) + 10'd1; phase_reg <= PH_LITERAL;
                        end
                    end
                    PH_COUNTER: begin
                        if (byte_reg[7]) begin
                            held_reg <= byte_reg; phase_reg <= PH_NUMBER;
                        end else begin
                            run_reg <= 10'(byte_reg) + 10'd1; phase_reg <= PH_LITERAL;
                        end
                    end
                    PH_NUMBER: begin
                        run_reg <= ({2'b0, byte_reg[7:6], 6'b0} << 1)
                                   + 10'(held_reg[6:0]) + 10'd3;
                        src_reg <= (SW)'(wpos_reg) + (SW)'(1)
                                   + (SW)'($signed(tab_rd_reg));
                        phase_reg <= PH_COPY;
                    end
                    PH_LITERAL: begin
                        if (run_reg <= 10'd1) begin
                            run_reg <= '0; phase_reg <= PH_COUNTER;
                        end else run_reg <= run_reg - 1'b1;
                    end
                    default: ;
                endcase
            end else if (func_reg == FN_TICK && phase_reg == PH_COPY) begin
                if (src_bad) flags_reg[0] <= 1'b1;
                src_reg <= src_reg + 1'b1;
                if (run_reg <= 10'd1) begin
                    run_reg <= '0; phase_reg <= PH_COUNTER;
                end else run_reg <= run_reg - 1'b1;
            end
            if (do_emit && func_reg != FN_END) begin
                if (wpos_reg >= limit_reg) flags_reg[1] <= 1'b1;
                else begin
                    res_valid <= 1'b1;
                    res_kind <= KIND_BYTE;
                    res_addr <= col_reg + rbase_reg[15:0];
                    res_value <= ~emit_b;
                    wpos_reg <= wpos_reg + 1'b1;
                    if (17'(rowc_reg) + 17'd1 >= 17'(band_height)) begin
                        rowc_reg <= '0; rbase_reg <= '0; col_reg <= col_reg + 1'b1;
                    end else begin
                        rowc_reg <= rowc_reg + 1'b1;
                        rbase_reg <= rbase_reg + 17'(band_width[15:3]);
                    end
                end
            end
        end
        if (!aresetn || cmd.clear_step) begin
            wpos_reg <= '0; phase_reg <= PH_HEADER; hcnt_reg <= '0; raw_reg <= '0;
            held_reg <= '0; run_reg <= '0; src_reg <= '0; col_reg <= '0;
            rowc_reg <= '0; rbase_reg <= '0; flags_reg <= '0;
            res_valid <= 1'b0;
            if (!aresetn) clr_reg <= '0;
        end
    end
endmodule
`default_nettype wire

### dv/band_lz_decompress_rotate_core_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module band_lz_decompress_rotate_core_tb;
    import bldr_pkg::*;

    // a small store keeps the clearing pass short; band size logic is unchanged
    localparam int STORE_BYTES = 1024;
    localparam int TABLE_SIZE = 64;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [7:0]  val;
        logic [2:0]  st;
    } band_result_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data;
        logic       typed;   // expected result typed in below
        logic       has_res;
        logic [1:0] kind;
        logic [2:0] st;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // in_byte
    logic [1:0]  s_tuser = '0;   // func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // out_address, out_value, status
    logic [1:0]  m_tuser;        // out_kind
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    band_lz_decompress_rotate_core #(.BAND_BYTES(STORE_BYTES)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // shadow copy of the decompressor state
    logic [15:0] width_px, height_px;
    logic        big_endian;
    logic [7:0]  band_mem [STORE_BYTES];
    logic [15:0] offs [TABLE_SIZE];
    int unsigned wpos, hdr_cnt, held_ctr, run_left, col, row, rbase;
    logic [31:0] raw_left;
    logic [2:0]  phase;
    logic [2:0]  flags;
    int          copy_src;

    band_result_t pending_results[$];
    int  errors = 0;
    int  items_sent = 0;
    bit  quiet = 0;       // no idling in the last part of the run
    int  sink_stall = 0;

    localparam logic [2:0] FL_REF = 3'd1, FL_OVER = 3'd2, FL_TRUNC = 3'd4;

    function automatic int unsigned band_size();
        longint unsigned bs;
        bs = (longint'(width_px) * longint'(height_px) + 7) >> 3;
        if (bs > STORE_BYTES) bs = STORE_BYTES;
        return int'(bs);
    endfunction

    function automatic void clear_band();
        foreach (band_mem[i]) band_mem[i] = 8'hff;
        foreach (offs[i]) offs[i] = '0;
        wpos = 0; hdr_cnt = 0; raw_left = '0; held_ctr = 0; run_left = 0;
        copy_src = 0; col = 0; row = 0; rbase = 0; flags = '0;
        phase = PH_HEADER;
    endfunction

    // store one decompressed byte and form its rotated output transaction
    function automatic bit write_byte(input logic [7:0] b, output band_result_t r);
        if (wpos >= band_size()) begin
            flags |= FL_OVER;
            return 0;
        end
        band_mem[wpos] = b;
        r = '{KIND_BYTE, 16'((col + rbase) & 32'hffff), ~b, ST_OK};
        wpos++;
        if (row + 1 >= height_px) begin
            row = 0;
            rbase = 0;
            col = (col + 1) & 32'hffff;
        end else begin
            row++;
            rbase = (rbase + (width_px >> 3)) & 32'h1ffff;
        end
        return 1;
    endfunction

    function automatic void take_counter(input logic [7:0] b);
        if (b[7]) begin
            held_ctr = b;
            phase = PH_NUMBER;
        end else begin
            run_left = b + 1;
            phase = PH_LITERAL;
        end
    endfunction

    function automatic void next_copy_step();
        if (run_left <= 1) begin
            run_left = 0;
            phase = PH_COUNTER;
        end else begin
            run_left--;
        end
    endfunction

    function automatic bit decompress_step(input logic [1:0] func, input logic [7:0] b,
                                           output band_result_t r);
        int unsigned n, k;
        logic [15:0] w;
        logic [7:0]  v;
        logic [2:0]  st;
        r = '0;
        case (func)
            FN_PUSH: begin
                case (phase)
                    PH_HEADER: begin
                        n = hdr_cnt;
                        if (n < 4) begin
                            if (big_endian) raw_left = {raw_left[23:0], b};
                            else raw_left |= 32'(b) << (8 * n);
                        end else begin
                            k = ((n - 4) >> 1) & (TABLE_SIZE - 1);
                            if (((n - 4) & 1) == 0) begin
                                offs[k] = big_endian ? {b, 8'h00} : {8'h00, b};
                            end else begin
                                w = offs[k] | (big_endian ? {8'h00, b} : {b, 8'h00});
                                offs[k] = ~w;
                            end
                        end
                        hdr_cnt = n + 1;
                        if (hdr_cnt >= HEADER_LEN) phase = PH_RAW;
                        return 0;
                    end
                    PH_RAW: begin
                        if (raw_left > 0) begin
                            raw_left--;
                            return write_byte(b, r);
                        end
                        take_counter(b);
                        return 0;
                    end
                    PH_COUNTER: begin
                        take_counter(b);
                        return 0;
                    end
                    PH_NUMBER: begin
                        run_left = ((b & 8'hc0) << 1) + (held_ctr & 8'h7f) + 3;
                        copy_src = int'(wpos) + 1 + int'($signed(offs[b[5:0]]));
                        phase = PH_COPY;
                        return 0;
                    end
                    PH_LITERAL: begin
                        next_copy_step();
                        return write_byte(b, r);
                    end
                    default: begin
                        // push while a copy is still being drawn out
                        r = '{KIND_REFUSED, 16'h0, 8'h0, ST_OK};
                        return 1;
                    end
                endcase
            end
            FN_TICK: begin
                if (phase != PH_COPY) return 0;
                v = 8'hff;
                if (copy_src < 0 || copy_src >= int'(band_size())) flags |= FL_REF;
                else v = band_mem[copy_src & (STORE_BYTES - 1)];
                copy_src++;
                next_copy_step();
                return write_byte(v, r);
            end
            FN_END: begin
                if (phase == PH_HEADER) st = ST_SHORT;
                else if (phase == PH_RAW) st = ST_NODATA;
                else begin
                    if (phase != PH_COUNTER) flags |= FL_TRUNC;
                    if (flags & FL_REF) st = ST_REF;
                    else if (flags & FL_OVER) st = ST_OVER;
                    else if (flags & FL_TRUNC) st = ST_TRUNC;
                    else st = ST_OK;
                end
                r = '{KIND_STATUS, 16'h0, 8'h0, st};
                clear_band();
                return 1;
            end
            default: return 0;   // unused code, ignored
        endcase
    endfunction

    // drive one input transaction; the prediction is made once it is accepted
    task automatic send_item(input logic [1:0] func, input logic [7:0] b,
                             input bit typed = 0, input band_result_t typed_res = '0,
                             input bit typed_has = 0);
        band_result_t r;
        bit has;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        has = decompress_step(func, b, r);
        if (typed) begin
            has = typed_has;
            r = typed_res;
        end
        if (has) pending_results.push_back(r);
        items_sent++;
    endtask

    task automatic release_input();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // registers are only written with nothing in flight
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_WIDTH:  width_px = value;
            CFG_HEIGHT: height_px = value;
            CFG_BIGEND: big_endian = value[0];
            default: ;
        endcase
    endtask

    task automatic send_word(input logic [15:0] w);
        if (big_endian) begin
            send_item(FN_PUSH, w[15:8]);
            send_item(FN_PUSH, w[7:0]);
        end else begin
            send_item(FN_PUSH, w[7:0]);
            send_item(FN_PUSH, w[15:8]);
        end
    endtask

    // band, may end early: header, raw bytes, literal runs and copies, end of band
    task automatic run_band();
        int mode, n, c, lo, hi, len;
        logic [31:0] raw_cnt;
        logic [15:0] back_gap;
        bit cut;
        mode = $urandom_range(0, 19);
        if (mode == 0) begin
            // header cut short
            n = $urandom_range(0, HEADER_LEN - 1);
            repeat (n) send_item(FN_PUSH, 8'($urandom));
            send_item(FN_END, 8'($urandom));
            return;
        end
        raw_cnt = (mode == 1) ? $urandom : 32'($urandom_range(0, 6));
        send_word(big_endian ? raw_cnt[31:16] : raw_cnt[15:0]);
        send_word(big_endian ? raw_cnt[15:0] : raw_cnt[31:16]);
        for (int k = 0; k < TABLE_SIZE; k++) begin
            // a stored word d points d bytes behind the write position
            back_gap = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 24));
            send_word(back_gap);
        end
        if (mode == 1) begin
            repeat ($urandom_range(0, 8)) send_item(FN_PUSH, 8'($urandom));
            send_item(FN_END, 8'($urandom));
            return;
        end
        repeat (raw_cnt) send_item(FN_PUSH, 8'($urandom));
        if ($urandom_range(0, 9) == 0) begin
            send_item(FN_END, 8'($urandom));
            return;
        end
        cut = 0;
        repeat ($urandom_range(3, 12)) begin
            if (cut) break;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    c = ($urandom_range(0, 15) == 0) ? 127 : $urandom_range(0, 12);
                    send_item(FN_PUSH, 8'(c));
                    n = c + 1;
                    if ($urandom_range(0, 14) == 0) begin
                        n = $urandom_range(0, c);
                        cut = 1;
                    end
                    repeat (n) send_item(FN_PUSH, 8'($urandom));
                end
                4, 5, 6, 7, 8: begin
                    lo = ($urandom_range(0, 15) == 0) ? 127 : $urandom_range(0, 10);
                    hi = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 3) : 0;
                    send_item(FN_PUSH, 8'(8'h80 | lo));
                    if ($urandom_range(0, 19) == 0) begin
                        cut = 1;   // number byte missing
                        continue;
                    end
                    send_item(FN_PUSH, {2'(hi), 6'($urandom_range(0, 63))});
                    len = (hi << 7) + lo + 3;
                    if ($urandom_range(0, 14) == 0) begin
                        len = $urandom_range(0, len - 1);
                        cut = 1;
                    end
                    repeat (len) begin
                        if ($urandom_range(0, 9) == 0) send_item(FN_PUSH, 8'($urandom));
                        send_item(FN_TICK, 8'($urandom));
                    end
                end
                default: send_item($urandom_range(0, 1) ? FN_TICK : 2'd3, 8'($urandom));
            endcase
        end
        send_item(FN_END, 8'($urandom));
    endtask

    // result side: random stall bursts, none in the last part
    always @(posedge aclk) begin
        if (quiet) begin
            m_tready <= 1'b1;
        end else if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            sink_stall <= $urandom_range(0, 12);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        band_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tuser, m_tdata[15:0], m_tdata[23:16], m_tdata[26:24]};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result kind %0d addr %h value %h status %0d",
                         $time, got.kind, got.addr, got.val, got.st);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.kind != want.kind)
                    $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
                if (got.addr != want.addr)
                    $display("%0t: address expected %h actual %h", $time, want.addr, got.addr);
                if (got.val != want.val)
                    $display("%0t: value expected %h actual %h", $time, want.val, got.val);
                if (got.st != want.st)
                    $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
                if (got != want) errors++;
            end
        end
    end

    // directed rows: end of band in the header, idle tick, unused code, short header
    stim_row_t directed[] = '{
        '{FN_END,  8'h00, 1, 1, KIND_STATUS, ST_SHORT},
        '{FN_TICK, 8'hff, 1, 0, KIND_BYTE,   ST_OK},
        '{2'd3,    8'ha5, 1, 0, KIND_BYTE,   ST_OK},
        '{FN_PUSH, 8'h00, 1, 0, KIND_BYTE,   ST_OK},
        '{FN_PUSH, 8'hff, 1, 0, KIND_BYTE,   ST_OK},
        '{FN_TICK, 8'h5a, 1, 0, KIND_BYTE,   ST_OK},
        '{FN_END,  8'hff, 1, 1, KIND_STATUS, ST_SHORT}
    };

    // band geometry per phase, extremes first
    logic [15:0] geom_w[] = '{16'd4960, 16'd8, 16'd65535, 16'd8, 16'd65535, 16'd64};
    logic [15:0] geom_h[] = '{16'd128, 16'd1, 16'd65535, 16'd65535, 16'd1, 16'd16};

    initial begin
        width_px = 16'd4960;
        height_px = 16'd128;
        big_endian = 1'b1;
        clear_band();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i])
            send_item(directed[i].func, directed[i].data, directed[i].typed,
                      '{directed[i].kind, 16'h0, 8'h0, directed[i].st}, directed[i].has_res);
        release_input();

        for (int p = 0; items_sent < 1700; p++) begin
            if (p < geom_w.size()) begin
                write_reg(CFG_WIDTH, geom_w[p]);
                write_reg(CFG_HEIGHT, geom_h[p]);
                write_reg(CFG_BIGEND, 16'(p & 1));
            end else begin
                write_reg(CFG_WIDTH, 16'($urandom_range(8, 400)));
                write_reg(CFG_HEIGHT, 16'($urandom_range(1, 40)));
                write_reg(CFG_BIGEND, 16'($urandom_range(0, 1)));
            end
            repeat (2) begin
                if (items_sent > 1450) quiet = 1;
                run_band();
            end
            release_input();
        end

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0)
            $display("[band_lz_decompress_rotate_core] OK");
        else
            $display("[band_lz_decompress_rotate_core] ERROR");
        $finish;
    end

    // run limit, far above the slowest correct run
    initial begin
        #20_000_000;
        $display("[band_lz_decompress_rotate_core] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
